// ===== hw/rtl/escape_arrow_key_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape arrow key decoder
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_ARROW_KEY_DECODER_CORE_MACROS_SVH
`define ESCAPE_ARROW_KEY_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define EAKD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("eakd assertion failed");

// next-cycle implication
`define EAKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("eakd assertion failed");

`endif

// ===== hw/rtl/eakd_pkg.sv =====
// ----------------------------------------------------------------------------
// eakd_pkg
// Types, codes and helpers shared by the escape arrow key decoder.
// ----------------------------------------------------------------------------
package eakd_pkg;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_LEAD = 2'd1;
    localparam logic [1:0] MODE_TAIL = 2'd2;

    localparam logic [7:0] ESC_BYTE      = 8'h1b;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHAR_O        = 8'h4f;
    localparam logic [7:0] CHAR_A        = 8'h41;
    localparam logic [7:0] CHAR_D        = 8'h44;
    localparam logic [7:0] TICK_MAX      = 8'hff;

    localparam logic [7:0] LEAD_TIMEOUT_RESET = 8'd20;
    localparam logic [7:0] TAIL_TIMEOUT_RESET = 8'd10;

    localparam logic REG_LEAD_TIMEOUT = 1'b0;
    localparam logic REG_TAIL_TIMEOUT = 1'b1;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] rx_byte;
    } t_poll_word;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       is_arrow;
        logic [1:0] arrow_dir;
        logic       last_of_run;
    } t_key_word;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] held_lead;
        logic [7:0] wait_ticks;
    } t_esc_state;

    typedef struct packed {
        logic [7:0] lead_timeout_ticks;
        logic [7:0] tail_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                       count;
        t_key_word [MAX_RESULTS-1:0]      words;
    } t_dec_res;

    typedef struct packed {
        logic [2:0] count;
        logic       room;
    } t_fifo_stat;

    function automatic t_key_word mk_raw(input logic [7:0] b);
        t_key_word w;
        w.key_byte    = b;
        w.is_arrow    = 1'b0;
        w.arrow_dir   = 2'd0;
        w.last_of_run = 1'b0;
        return w;
    endfunction

endpackage

// ===== hw/rtl/eakd_decode.sv =====
// ----------------------------------------------------------------------------
// eakd_decode
// One step of the escape sequence decoder: state and poll in, next state
// and up to three key words out.
// ----------------------------------------------------------------------------
module eakd_decode import eakd_pkg::*; (
    input  t_esc_state i_state,
    input  t_poll_word i_poll,
    input  t_cfg       i_cfg,
    output t_esc_state o_state,
    output t_dec_res   o_res
);

    logic [7:0] b;
    logic [7:0] tick_inc;
    logic [7:0] limit;
    logic       lead_ok_b;
    logic       lead_ok_held;
    logic       tail_ok;
    logic [7:0] dir_full;

    assign b            = i_poll.rx_byte;
    assign tick_inc     = (i_state.wait_ticks == TICK_MAX) ? TICK_MAX
                                                           : i_state.wait_ticks + 8'd1;
    assign limit        = (i_state.mode == MODE_TAIL) ? i_cfg.tail_timeout_ticks
                                                      : i_cfg.lead_timeout_ticks;
    assign lead_ok_b    = b inside {CHAR_LBRACKET, CHAR_O};
    assign lead_ok_held = i_state.held_lead inside {CHAR_LBRACKET, CHAR_O};
    assign tail_ok      = b inside {[CHAR_A:CHAR_D]};
    assign dir_full     = b - CHAR_A;

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        case (i_state.mode)
            MODE_LEAD, MODE_TAIL: begin
                if (i_poll.has_byte) begin
                    o_state.wait_ticks = 8'd0;
                    if (i_state.mode == MODE_LEAD) begin
                        o_state.held_lead = b;
                        if (lead_ok_b) begin
                            o_state.mode = MODE_TAIL;
                        end else begin
                            o_state.mode   = MODE_IDLE;
                            o_res.words[0] = mk_raw(ESC_BYTE);
                            o_res.words[1] = mk_raw(b);
                            o_res.count    = 2'd2;
                        end
                    end else begin
                        o_state.mode = MODE_IDLE;
                        if (lead_ok_held && tail_ok) begin
                            o_res.words[0].is_arrow  = 1'b1;
                            o_res.words[0].arrow_dir = dir_full[1:0];
                            o_res.count              = 2'd1;
                        end else begin
                            o_res.words[0] = mk_raw(ESC_BYTE);
                            o_res.words[1] = mk_raw(i_state.held_lead);
                            o_res.words[2] = mk_raw(b);
                            o_res.count    = 2'd3;
                        end
                    end
                end else begin
                    o_state.wait_ticks = tick_inc;
                    if (tick_inc >= limit) begin
                        o_state.mode   = MODE_IDLE;
                        o_res.words[0] = mk_raw(ESC_BYTE);
                        if (i_state.mode == MODE_TAIL) begin
                            o_res.words[1] = mk_raw(i_state.held_lead);
                            o_res.count    = 2'd2;
                        end else begin
                            o_res.count    = 2'd1;
                        end
                    end
                end
            end
            default: begin
                o_state.mode = MODE_IDLE;
                if (i_poll.has_byte) begin
                    if (b != ESC_BYTE) begin
                        o_res.words[0] = mk_raw(b);
                        o_res.count    = 2'd1;
                    end else begin
                        o_state.mode       = MODE_LEAD;
                        o_state.wait_ticks = 8'd0;
                    end
                end
            end
        endcase

        case (o_res.count)
            2'd1:    o_res.words[0].last_of_run = 1'b1;
            2'd2:    o_res.words[1].last_of_run = 1'b1;
            2'd3:    o_res.words[2].last_of_run = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/eakd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// eakd_out_fifo
// Result queue: takes up to three key words a cycle, hands out one a cycle unless stalled.
// ----------------------------------------------------------------------------
module eakd_out_fifo import eakd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_dec_res   i_res,
    output logic       o_valid,
    input  logic       i_stall,
    output t_key_word  o_word,
    output t_fifo_stat o_stat
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_key_word         r_mem [FIFO_DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic [PW-1:0]     n_wr;
    logic [PW-1:0]     n_rd;
    logic [CW-1:0]     n_cnt;
    logic              pop;
    logic [1:0]        push_n;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    assign push_n  = i_push ? i_res.count : 2'd0;

    assign o_stat.count = 3'(r_cnt);
    assign o_stat.room  = (r_cnt <= CW'(FIFO_DEPTH - MAX_RESULTS)) ||
                          (pop && (r_cnt == CW'(FIFO_DEPTH - MAX_RESULTS + 1)));

    assign n_wr  = r_wr + PW'(push_n);
    assign n_rd  = r_rd + PW'(pop);
    assign n_cnt = r_cnt + CW'(push_n) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push_n) begin
                r_mem[r_wr + PW'(i)] <= i_res.words[i];
            end
        end
    end

endmodule

// ===== hw/rtl/escape_arrow_key_decoder_core.sv =====
// ----------------------------------------------------------------------------
// escape_arrow_key_decoder_core: ANSI arrow key decoder with tick timeouts
// An accepted poll word is registered, then decoded and pushed into the queue.
// Throughput: 1 poll word a cycle while each yields at most one key word and
// the output is not stalled; key words leave 1 a cycle from a 4-entry queue,
// and the input stalls while the queue cannot take three more.
// Reset: synchronous active low; idle, empty queue, timeouts 20 and 10.
// ----------------------------------------------------------------------------
module escape_arrow_key_decoder_core import eakd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_poll_word i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_key_word  o_out_word,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

`include "escape_arrow_key_decoder_core_macros.svh"

    t_cfg       r_cfg;
    t_esc_state r_state;
    t_esc_state n_state;
    logic       r_in_valid;
    t_poll_word r_in_word;
    t_dec_res   dec_res;
    t_fifo_stat stat;
    logic       fire;
    logic       accept;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TAIL_TIMEOUT) ? {24'd0, r_cfg.tail_timeout_ticks}
                                                   : {24'd0, r_cfg.lead_timeout_ticks};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_timeout_ticks <= LEAD_TIMEOUT_RESET;
            r_cfg.tail_timeout_ticks <= TAIL_TIMEOUT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TAIL_TIMEOUT) begin
                r_cfg.tail_timeout_ticks <= pwdata[7:0];
            end else begin
                r_cfg.lead_timeout_ticks <= pwdata[7:0];
            end
        end
    end

    assign fire       = r_in_valid && stat.room;
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    eakd_decode u_decode (
        .i_state (r_state),
        .i_poll  (r_in_word),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (dec_res)
    );

    eakd_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_res   (dec_res),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word),
        .o_stat  (stat)
    );

    `EAKD_ASSERT_IMPL(a_fifo_bound, 1'b1, stat.count <= 3'(FIFO_DEPTH))
    `EAKD_ASSERT_NEXT(a_idle_after_burst, fire && (dec_res.count != 2'd0), r_state.mode == MODE_IDLE)
    `EAKD_ASSERT_IMPL(a_arrow_zero_byte, o_out_valid && o_out_word.is_arrow, o_out_word.key_byte == 8'd0)

endmodule
